// ===== src/scs_pkg.sv =====
// Shared types and constants of the shape coverage shader.
package scs_pkg;

    typedef enum logic [1:0] {
        SHAPE_CIRCLE = 2'd0,
        SHAPE_RECT   = 2'd1,
        SHAPE_TRI    = 2'd2
    } shape_mode_t;

    typedef enum logic [2:0] {
        CFG_SHAPE_MODE = 3'd0,
        CFG_PT0_X      = 3'd1,
        CFG_PT0_Y      = 3'd2,
        CFG_PT1_X      = 3'd3,
        CFG_PT1_Y      = 3'd4,
        CFG_PT2_X      = 3'd5,
        CFG_PT2_Y      = 3'd6,
        CFG_RADIUS     = 3'd7
    } cfg_index_t;

    localparam int CFG_DATA_W = 13;

    localparam logic [7:0] FG_RED   = 8'd255;
    localparam logic [7:0] FG_GREEN = 8'd220;
    localparam logic [7:0] FG_BLUE  = 8'd50;
    localparam logic [7:0] BG_RED   = 8'd30;
    localparam logic [7:0] BG_GREEN = 8'd30;
    localparam logic [7:0] BG_BLUE  = 8'd30;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } pix_in_t;

    typedef struct packed {
        logic       covered;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_out_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } scs_adv_t;

endpackage

// ===== src/scs_edge_unit.sv =====
// Three-stage pipelined edge function with sign flags of the result.
module scs_edge_unit (
    input  logic                 aclk,
    input  scs_pkg::scs_adv_t    adv,
    input  logic signed [12:0]   ax,
    input  logic signed [12:0]   ay,
    input  logic signed [12:0]   bx,
    input  logic signed [12:0]   by,
    input  logic [11:0]          px,
    input  logic [11:0]          py,
    output logic                 neg,
    output logic                 pos
);

    logic signed [13:0] ex_reg, ey_reg, qx_reg, qy_reg;
    logic signed [27:0] p0_next, p1_next;
    logic signed [27:0] p0_reg, p1_reg;
    logic signed [28:0] e_next;
    logic               neg_reg, pos_reg;

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            ex_reg <= {bx[12], bx} - {ax[12], ax};
            ey_reg <= {by[12], by} - {ay[12], ay};
            qx_reg <= {2'b00, px} - {ax[12], ax};
            qy_reg <= {2'b00, py} - {ay[12], ay};
        end
    end

    assign p0_next = ex_reg * qy_reg;
    assign p1_next = ey_reg * qx_reg;

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
    end

    assign e_next = p0_reg - p1_reg;

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            neg_reg <= e_next[28];
            pos_reg <= !e_next[28] && (e_next != 29'sd0);
        end
    end

    assign neg = neg_reg;
    assign pos = pos_reg;

endmodule

// ===== src/shape_coverage_shader_unit.sv =====
// Top level of the shape coverage shader: one pixel word in, one color word out.
// Four register stages: difference, multiply, add and compare, then the output word.
// Throughput: one word per cycle unless m_ready is low with the pipeline full, which
// stalls the stages and drops s_ready. Reset (aresetn low,
// synchronous) empties the pipeline and sets all configuration registers to zero.
module shape_coverage_shader_unit #(
    parameter int IMAGE_WIDTH  = 1920,
    parameter int IMAGE_HEIGHT = 1080
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  scs_pkg::pix_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output scs_pkg::pix_out_t                  m_data
);

    localparam logic [11:0] LAST_COL = 12'(IMAGE_WIDTH - 1);
    localparam logic [11:0] LAST_ROW = 12'(IMAGE_HEIGHT - 1);

    logic [1:0]         mode_reg;
    logic signed [12:0] pt0x_reg, pt0y_reg, pt1x_reg, pt1y_reg, pt2x_reg, pt2y_reg;
    logic [11:0]        radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 2'd0;
            pt0x_reg   <= '0;
            pt0y_reg   <= '0;
            pt1x_reg   <= '0;
            pt1y_reg   <= '0;
            pt2x_reg   <= '0;
            pt2y_reg   <= '0;
            radius_reg <= '0;
        end else if (cfg_we) begin
            unique case (scs_pkg::cfg_index_t'(cfg_index))
                scs_pkg::CFG_SHAPE_MODE: mode_reg   <= cfg_wdata[1:0];
                scs_pkg::CFG_PT0_X:      pt0x_reg   <= cfg_wdata;
                scs_pkg::CFG_PT0_Y:      pt0y_reg   <= cfg_wdata;
                scs_pkg::CFG_PT1_X:      pt1x_reg   <= cfg_wdata;
                scs_pkg::CFG_PT1_Y:      pt1y_reg   <= cfg_wdata;
                scs_pkg::CFG_PT2_X:      pt2x_reg   <= cfg_wdata;
                scs_pkg::CFG_PT2_Y:      pt2y_reg   <= cfg_wdata;
                scs_pkg::CFG_RADIUS:     radius_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor loads.
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic en1, en2, en3, en_out;
    scs_pkg::scs_adv_t adv;

    assign en_out = !m_valid_reg || m_ready;
    assign en3    = !v3_reg || en_out;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign adv    = '{s1: en1, s2: en2, s3: en3};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg      <= s_valid;
            if (en2)    v2_reg      <= v1_reg;
            if (en3)    v3_reg      <= v2_reg;
            if (en_out) m_valid_reg <= v3_reg;
        end
    end

    // Stage 1: border flag, rectangle test and circle offsets.
    logic signed [13:0] col_s, row_s;
    logic signed [13:0] xl, xh, yl, yh;
    logic               border_next, rect_next;
    logic               border1_reg, rect1_reg;
    logic signed [13:0] dx_reg, dy_reg;

    assign col_s = {2'b00, s_data.pixel_col};
    assign row_s = {2'b00, s_data.pixel_row};

    always_comb begin
        if (pt1x_reg < pt2x_reg) begin
            xl = {pt1x_reg[12], pt1x_reg};
            xh = {pt2x_reg[12], pt2x_reg};
        end else begin
            xl = {pt2x_reg[12], pt2x_reg};
            xh = {pt1x_reg[12], pt1x_reg};
        end
        if (pt1y_reg < pt2y_reg) begin
            yl = {pt1y_reg[12], pt1y_reg};
            yh = {pt2y_reg[12], pt2y_reg};
        end else begin
            yl = {pt2y_reg[12], pt2y_reg};
            yh = {pt1y_reg[12], pt1y_reg};
        end
        rect_next   = (col_s >= xl) && (col_s <= xh) && (row_s >= yl) && (row_s <= yh);
        border_next = (s_data.pixel_col == 12'd0) || (s_data.pixel_col == LAST_COL) ||
                      (s_data.pixel_row == 12'd0) || (s_data.pixel_row == LAST_ROW);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            border1_reg <= border_next;
            rect1_reg   <= rect_next;
            dx_reg      <= col_s - {pt0x_reg[12], pt0x_reg};
            dy_reg      <= row_s - {pt0y_reg[12], pt0y_reg};
        end
    end

    // Stage 2: squares.
    logic signed [27:0] dx2_next, dy2_next;
    logic [23:0]        rr_next;
    logic [25:0]        dx2_reg, dy2_reg;
    logic [23:0]        rr_reg;
    logic               border2_reg, rect2_reg;

    assign dx2_next = dx_reg * dx_reg;
    assign dy2_next = dy_reg * dy_reg;
    assign rr_next  = radius_reg * radius_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            dx2_reg     <= dx2_next[25:0];
            dy2_reg     <= dy2_next[25:0];
            rr_reg      <= rr_next;
            border2_reg <= border1_reg;
            rect2_reg   <= rect1_reg;
        end
    end

    // Stage 3: distance compare.
    logic [26:0] dist_next;
    logic        circ3_reg, border3_reg, rect3_reg;

    assign dist_next = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_ff @(posedge aclk) begin
        if (en3) begin
            circ3_reg   <= dist_next < {3'b000, rr_reg};
            border3_reg <= border2_reg;
            rect3_reg   <= rect2_reg;
        end
    end

    logic e0_neg, e0_pos, e1_neg, e1_pos, e2_neg, e2_pos;

    scs_edge_unit u_edge0 (
        .aclk(aclk), .adv(adv),
        .ax(pt0x_reg), .ay(pt0y_reg), .bx(pt1x_reg), .by(pt1y_reg),
        .px(s_data.pixel_col), .py(s_data.pixel_row),
        .neg(e0_neg), .pos(e0_pos)
    );

    scs_edge_unit u_edge1 (
        .aclk(aclk), .adv(adv),
        .ax(pt1x_reg), .ay(pt1y_reg), .bx(pt2x_reg), .by(pt2y_reg),
        .px(s_data.pixel_col), .py(s_data.pixel_row),
        .neg(e1_neg), .pos(e1_pos)
    );

    scs_edge_unit u_edge2 (
        .aclk(aclk), .adv(adv),
        .ax(pt2x_reg), .ay(pt2y_reg), .bx(pt0x_reg), .by(pt0y_reg),
        .px(s_data.pixel_col), .py(s_data.pixel_row),
        .neg(e2_neg), .pos(e2_pos)
    );

    // Output stage: shape select and color.
    logic              tri_hit, shape_hit, hit;
    scs_pkg::pix_out_t out_next;
    scs_pkg::pix_out_t out_reg;

    always_comb begin
        tri_hit = !((e0_neg || e1_neg || e2_neg) && (e0_pos || e1_pos || e2_pos));
        case (scs_pkg::shape_mode_t'(mode_reg))
            scs_pkg::SHAPE_CIRCLE: shape_hit = circ3_reg;
            scs_pkg::SHAPE_RECT:   shape_hit = rect3_reg;
            default:               shape_hit = tri_hit;
        endcase
        hit = shape_hit && !border3_reg;
        out_next.covered = hit;
        out_next.red     = hit ? scs_pkg::FG_RED   : scs_pkg::BG_RED;
        out_next.green   = hit ? scs_pkg::FG_GREEN : scs_pkg::BG_GREEN;
        out_next.blue    = hit ? scs_pkg::FG_BLUE  : scs_pkg::BG_BLUE;
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_reg <= out_next;
        end
    end

    assign s_ready = en1;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/scs_checker.sv =====
// Port-level checks of the shape coverage shader and their binding to the top level.
module scs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input scs_pkg::pix_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result word changed while stalled.");

    a_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_data.covered && m_data.red == scs_pkg::FG_RED &&
             m_data.green == scs_pkg::FG_GREEN && m_data.blue == scs_pkg::FG_BLUE) ||
            (!m_data.covered && m_data.red == scs_pkg::BG_RED &&
             m_data.green == scs_pkg::BG_GREEN && m_data.blue == scs_pkg::BG_BLUE))
        else $error("Color does not match coverage flag.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("Accepted word did not reach the output in time.");

    a_ready_when_empty: assert property (@(posedge aclk)
        !m_valid |-> s_ready)
        else $error("Input stalled with an empty output.");

endmodule

bind shape_coverage_shader_unit scs_checker u_scs_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the shape coverage shader: directed and random pixel words.
module testbench;

    localparam int IMG_W = 1920;
    localparam int IMG_H = 1080;
    localparam int PIPE_DEPTH = 4;
    localparam int PHASES = 14;
    localparam int WORDS_PER_PHASE = 132;
    localparam int HOLD_CYCLES = 150;
    localparam int PLAN_LEN = 56;
    localparam logic [1:0] SHAPE_SPARE = 2'd3;

    typedef enum {PLAN_WRITE, PLAN_PIXEL} plan_kind_t;
    typedef enum {EXP_MODEL, EXP_CLEAR, EXP_HIT} plan_check_t;

    typedef struct {
        plan_kind_t          kind;
        scs_pkg::cfg_index_t index;
        logic [12:0]         value;
        logic [11:0]         col;
        logic [11:0]         row;
        plan_check_t         check;
    } plan_row_t;

    plan_row_t directed_plan [PLAN_LEN] = '{
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd5, 12'd5, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd4095, 12'd4095, EXP_CLEAR},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_X, 13'd1, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_Y, 13'd1, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_RADIUS, 13'd4095, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd0, 12'd1, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd1919, 12'd5, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd5, 12'd1079, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd5, 12'd0, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd1918, 12'd1078, EXP_HIT},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd4095, 12'd4095, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd1920, 12'd1080, EXP_HIT},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_X, 13'd100, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_Y, 13'd100, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_RADIUS, 13'd10, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd110, 12'd100, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd109, 12'd100, EXP_HIT},
        '{PLAN_WRITE, scs_pkg::CFG_SHAPE_MODE, 13'(scs_pkg::SHAPE_RECT), 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_X, 13'd200, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_Y, 13'd50, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_X, 13'd100, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_Y, 13'd150, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd100, 12'd50, EXP_HIT},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd200, 12'd150, EXP_HIT},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd201, 12'd100, EXP_CLEAR},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd150, 12'd49, EXP_CLEAR},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_X, 13'h1000, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_Y, 13'h1000, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_X, 13'h0FFF, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_Y, 13'h0FFF, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd4095, 12'd4095, EXP_HIT},
        '{PLAN_WRITE, scs_pkg::CFG_SHAPE_MODE, 13'(scs_pkg::SHAPE_TRI), 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_X, 13'd10, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_Y, 13'd10, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_X, 13'd100, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_Y, 13'd10, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_X, 13'd10, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_Y, 13'd100, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd10, 12'd10, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd55, 12'd55, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd56, 12'd56, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_X, 13'd20, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_Y, 13'd20, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_X, 13'd30, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_Y, 13'd30, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd15, 12'd15, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd15, 12'd16, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_SHAPE_MODE, 13'(SHAPE_SPARE), 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_X, 13'h1000, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT0_Y, 13'h0FFF, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_X, 13'h1000, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT1_Y, 13'h0FFF, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_X, 13'h1000, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_WRITE, scs_pkg::CFG_PT2_Y, 13'h0FFF, 12'd0, 12'd0, EXP_MODEL},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd2000, 12'd2000, EXP_HIT},
        '{PLAN_PIXEL, scs_pkg::CFG_SHAPE_MODE, 13'd0, 12'd4095, 12'd0, EXP_CLEAR}
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [2:0]                     cfg_index;
    logic [scs_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    scs_pkg::pix_in_t               s_data;
    logic                           m_valid;
    logic                           m_ready;
    scs_pkg::pix_out_t              m_data;

    logic [1:0]         shape_sel;
    logic signed [12:0] pt_x [3];
    logic signed [12:0] pt_y [3];
    logic [11:0]        radius;

    scs_pkg::pix_out_t expected_colors [$];
    bit       quiet_phase;
    bit       hold_request;
    bit       pipeline_busy;
    int       faults;
    int       words_sent;
    int       words_checked;
    int       words_covered;
    int       regs_written;
    int       input_stalls;

    shape_coverage_shader_unit #(
        .IMAGE_WIDTH (IMG_W),
        .IMAGE_HEIGHT(IMG_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic scs_pkg::pix_out_t paint(input bit hit);
        scs_pkg::pix_out_t res;
        res.covered = hit;
        res.red     = hit ? scs_pkg::FG_RED : scs_pkg::BG_RED;
        res.green   = hit ? scs_pkg::FG_GREEN : scs_pkg::BG_GREEN;
        res.blue    = hit ? scs_pkg::FG_BLUE : scs_pkg::BG_BLUE;
        return res;
    endfunction

    function automatic longint edge_fn(input longint ax, input longint ay, input longint bx,
                                       input longint by, input longint px, input longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function automatic scs_pkg::pix_out_t shade_pixel(input scs_pkg::pix_in_t px);
        longint c, r, rad, dx, dy, xl, xh, yl, yh, e0, e1, e2;
        longint vx [3];
        longint vy [3];
        bit hit;
        c = px.pixel_col;
        r = px.pixel_row;
        rad = radius;
        vx[0] = pt_x[0]; vy[0] = pt_y[0];
        vx[1] = pt_x[1]; vy[1] = pt_y[1];
        vx[2] = pt_x[2]; vy[2] = pt_y[2];
        hit = 1'b0;
        if (!(c == 0 || c == IMG_W - 1 || r == 0 || r == IMG_H - 1)) begin
            case (shape_sel)
                scs_pkg::SHAPE_CIRCLE: begin
                    dx = c - vx[0];
                    dy = r - vy[0];
                    hit = dx * dx + dy * dy < rad * rad;
                end
                scs_pkg::SHAPE_RECT: begin
                    xl = (vx[1] < vx[2]) ? vx[1] : vx[2];
                    xh = (vx[1] < vx[2]) ? vx[2] : vx[1];
                    yl = (vy[1] < vy[2]) ? vy[1] : vy[2];
                    yh = (vy[1] < vy[2]) ? vy[2] : vy[1];
                    hit = c >= xl && c <= xh && r >= yl && r <= yh;
                end
                default: begin
                    e0 = edge_fn(vx[0], vy[0], vx[1], vy[1], c, r);
                    e1 = edge_fn(vx[1], vy[1], vx[2], vy[2], c, r);
                    e2 = edge_fn(vx[2], vy[2], vx[0], vy[0], c, r);
                    hit = !((e0 < 0 || e1 < 0 || e2 < 0) && (e0 > 0 || e1 > 0 || e2 > 0));
                end
            endcase
        end
        return paint(hit);
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet_phase || p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic scs_pkg::pix_in_t pick_pixel();
        int pick, col, row, span, k;
        scs_pkg::pix_in_t px;
        pick = $urandom_range(0, 99);
        col = $urandom_range(0, IMG_W - 1);
        row = $urandom_range(0, IMG_H - 1);
        if (pick < 15) begin
            col = $urandom_range(0, 4095);
            row = $urandom_range(0, 4095);
        end else if (pick < 25) begin
            case ($urandom_range(0, 3))
                0: col = 0;
                1: col = IMG_W - 1;
                2: row = 0;
                default: row = IMG_H - 1;
            endcase
        end else if (pick < 65) begin
            k = (shape_sel == scs_pkg::SHAPE_CIRCLE) ? 0 : $urandom_range(0, 2);
            span = (shape_sel == scs_pkg::SHAPE_CIRCLE) ? int'(radius) + 2 : 24;
            col = int'(pt_x[k]) + int'($urandom_range(0, 2 * span)) - span;
            row = int'(pt_y[k]) + int'($urandom_range(0, 2 * span)) - span;
            if (col < 0) col = 0;
            if (col > 4095) col = 4095;
            if (row < 0) row = 0;
            if (row > 4095) row = 4095;
        end
        px.pixel_col = col[11:0];
        px.pixel_row = row[11:0];
        return px;
    endfunction

    function automatic logic [12:0] pick_coord(input int span);
        if ($urandom_range(0, 99) < 80)
            return 13'(int'($urandom_range(0, span + 200)) - 100);
        return 13'($urandom);
    endfunction

    task automatic write_reg(input scs_pkg::cfg_index_t idx, input logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            scs_pkg::CFG_SHAPE_MODE: shape_sel = value[1:0];
            scs_pkg::CFG_PT0_X:      pt_x[0] = value;
            scs_pkg::CFG_PT0_Y:      pt_y[0] = value;
            scs_pkg::CFG_PT1_X:      pt_x[1] = value;
            scs_pkg::CFG_PT1_Y:      pt_y[1] = value;
            scs_pkg::CFG_PT2_X:      pt_x[2] = value;
            scs_pkg::CFG_PT2_Y:      pt_y[2] = value;
            scs_pkg::CFG_RADIUS:     radius = value[11:0];
            default: ;
        endcase
        regs_written++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_pixel(input scs_pkg::pix_in_t px, input plan_check_t check);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        expected_colors.push_back(check == EXP_MODEL ? shade_pixel(px) : paint(check == EXP_HIT));
        words_sent++;
        pipeline_busy = 1'b1;
        @(negedge aclk);
    endtask

    task automatic settle_pipeline();
        if (pipeline_busy) begin
            s_valid <= 1'b0;
            while (expected_colors.size() != 0) @(negedge aclk);
            repeat (PIPE_DEPTH + 2) @(negedge aclk);
            pipeline_busy = 1'b0;
        end
    endtask

    task automatic configure_phase(input int phase);
        logic [12:0] mode_word, radius_word;
        logic [12:0] px [3];
        logic [12:0] py [3];
        mode_word = 13'(phase % 4);
        radius_word = ($urandom_range(0, 99) < 70) ? 13'($urandom_range(0, 700)) : 13'($urandom);
        for (int k = 0; k < 3; k++) begin
            px[k] = pick_coord(IMG_W);
            py[k] = pick_coord(IMG_H);
        end
        case (phase)
            0: begin
                mode_word = 13'(scs_pkg::SHAPE_TRI);
                px = '{13'h1000, 13'h0FFF, 13'h1000};
                py = '{13'h1000, 13'h1000, 13'h0FFF};
                radius_word = 13'h0FFF;
            end
            1: begin
                mode_word = 13'(scs_pkg::SHAPE_CIRCLE);
                px[0] = 13'h0FFF;
                py[0] = 13'h0FFF;
                radius_word = 13'h1FFF;
            end
            2: begin
                mode_word = {11'h7FF, scs_pkg::SHAPE_RECT};
                px[1] = 13'h1000; py[1] = 13'h0FFF;
                px[2] = 13'h0FFF; py[2] = 13'h1000;
            end
            3: begin
                mode_word = 13'(scs_pkg::SHAPE_CIRCLE);
                radius_word = 13'h1000;
            end
            default: ;
        endcase
        write_reg(scs_pkg::CFG_SHAPE_MODE, mode_word);
        write_reg(scs_pkg::CFG_PT0_X, px[0]);
        write_reg(scs_pkg::CFG_PT0_Y, py[0]);
        write_reg(scs_pkg::CFG_PT1_X, px[1]);
        write_reg(scs_pkg::CFG_PT1_Y, py[1]);
        write_reg(scs_pkg::CFG_PT2_X, px[2]);
        write_reg(scs_pkg::CFG_PT2_Y, py[2]);
        write_reg(scs_pkg::CFG_RADIUS, radius_word);
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : word_check
        scs_pkg::pix_out_t want;
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
        if (aresetn && m_valid && m_ready) begin
            words_checked++;
            if (m_data.covered)
                words_covered++;
            if (expected_colors.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("Unexpected word: covered=%0d rgb=%0d,%0d,%0d", m_data.covered,
                             m_data.red, m_data.green, m_data.blue);
            end else begin
                want = expected_colors.pop_front();
                if (m_data.covered !== want.covered || m_data.red !== want.red
                        || m_data.green !== want.green || m_data.blue !== want.blue) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("Mismatch on word %0d: expected covered=%0d rgb=%0d,%0d,%0d",
                                 words_checked, want.covered, want.red, want.green,
                                 want.blue);
                        $display("    got covered=%0d rgb=%0d,%0d,%0d",
                                 m_data.covered, m_data.red, m_data.green, m_data.blue);
                    end
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = scs_pkg::CFG_SHAPE_MODE;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        shape_sel = scs_pkg::SHAPE_CIRCLE;
        pt_x      = '{13'sd0, 13'sd0, 13'sd0};
        pt_y      = '{13'sd0, 13'sd0, 13'sd0};
        radius    = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == PLAN_WRITE) begin
                settle_pipeline();
                write_reg(directed_plan[i].index, directed_plan[i].value);
            end else begin
                send_pixel('{directed_plan[i].col, directed_plan[i].row},
                           directed_plan[i].check);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_pipeline();
            quiet_phase = (phase % 5 == 2);
            configure_phase(phase);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // Stall the result side long enough for the pipeline to back up into s_ready.
                if (phase == 6 && n == 30)
                    hold_request = 1'b1;
                send_pixel(pick_pixel(), EXP_MODEL);
            end
        end
        settle_pipeline();

        if (expected_colors.size() != 0)
            faults++;
        $display("Sent %0d pixel words over %0d shape settings (%0d register writes).",
                 words_sent, PHASES, regs_written);
        $display("Checked %0d words, %0d covered; input held off for %0d cycles.",
                 words_checked, words_covered, input_stalls);
        if (faults == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/scs_pkg.sv
src/scs_edge_unit.sv
src/shape_coverage_shader_unit.sv
src/scs_checker.sv
verif/testbench.sv
